### rtl/tcprw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcprw_pkg
// shared widths, request and phase codes, command/status types and helpers
// for the reno window controller
// ----------------------------------------------------------------------------
package tcprw_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned SEG_W  = 16;
  localparam int unsigned DUP_W  = 8;
  localparam int unsigned REQ_W  = 3;
  localparam int unsigned PH_W   = 2;
  localparam int unsigned CNT_W  = $clog2(DATA_W);

  // request codes
  localparam logic [REQ_W-1:0] REQ_ACK     = 3'd0;
  localparam logic [REQ_W-1:0] REQ_DUP     = 3'd1;
  localparam logic [REQ_W-1:0] REQ_TIMEOUT = 3'd2;
  localparam logic [REQ_W-1:0] REQ_PARTIAL = 3'd3;
  localparam logic [REQ_W-1:0] REQ_REINIT  = 3'd4;

  // phase codes
  localparam logic [PH_W-1:0] PH_SLOW  = 2'd0;
  localparam logic [PH_W-1:0] PH_AVOID = 2'd1;
  localparam logic [PH_W-1:0] PH_RECOV = 2'd2;

  localparam logic [DUP_W-1:0] DUP_TRIGGER = 8'd3;
  localparam logic [SEG_W-1:0] SEG_RESET   = 16'd1400;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic div_start;
    logic apply;
    logic load_out;
  } tcprw_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic need_pre_div;
    logic div_done;
  } tcprw_sts_t;

  function automatic logic [DATA_W-1:0] sat_add(input logic [DATA_W-1:0] a,
                                                input logic [DATA_W-1:0] b);
    logic [DATA_W:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    return sum[DATA_W] ? {DATA_W{1'b1}} : sum[DATA_W-1:0];
  endfunction

endpackage

### rtl/tcprw_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcprw_div
// restoring divider, one quotient bit per cycle, zero divisor gives zero
// ----------------------------------------------------------------------------
module tcprw_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [tcprw_pkg::DATA_W-1:0]  dividend_i,
  input  logic [tcprw_pkg::SEG_W-1:0]   divisor_i,
  output logic                          done_o,
  output logic [tcprw_pkg::DATA_W-1:0]  quotient_o
);
  import tcprw_pkg::*;

  logic              busy_q;
  logic              done_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [DATA_W-1:0] dvd_q;
  logic [SEG_W-1:0]  rem_q;
  logic [SEG_W:0]    rem_sh;
  logic [SEG_W:0]    rem_sub;
  logic              fits;

  assign rem_sh  = {rem_q, dvd_q[DATA_W-1]};
  assign fits    = rem_sh >= {1'b0, divisor_i};
  assign rem_sub = rem_sh - {1'b0, divisor_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_W'(DATA_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // dividend register doubles as quotient shift register
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      rem_q <= '0;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[DATA_W-2:0], fits};
      rem_q <= fits ? rem_sub[SEG_W-1:0] : rem_sh[SEG_W-1:0];
    end
  end

  assign done_o     = done_q;
  assign quotient_o = (divisor_i == '0) ? '0 : dvd_q;

  a_no_restart : assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q)
    else $error("divider restarted while busy");

  a_done_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q && $past(busy_q))
    else $error("divider done without a finished run");

  a_busy_from_start : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy_q) |-> $past(start_i))
    else $error("divider busy without a start");

endmodule

### rtl/tcprw_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcprw_datapath
// window state, event capture, update logic, divider and result registers
// ----------------------------------------------------------------------------
module tcprw_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  tcprw_pkg::tcprw_cmd_t         cmd_i,
  output tcprw_pkg::tcprw_sts_t         sts_o,
  input  logic                          cfg_we_i,
  input  logic [tcprw_pkg::SEG_W-1:0]   cfg_wdata_i,
  input  logic [tcprw_pkg::REQ_W-1:0]   req_type_i,
  input  logic [tcprw_pkg::DATA_W-1:0]  ack_number_i,
  input  logic [tcprw_pkg::DUP_W-1:0]   reported_dup_count_i,
  input  logic [tcprw_pkg::DATA_W-1:0]  flow_window_i,
  output logic                          ack_result_o,
  output logic                          retransmit_now_o,
  output logic [tcprw_pkg::DATA_W-1:0]  window_bytes_o,
  output logic [tcprw_pkg::DATA_W-1:0]  window_segments_o,
  output logic [tcprw_pkg::DATA_W-1:0]  threshold_bytes_o,
  output logic [tcprw_pkg::PH_W-1:0]    phase_code_o,
  output logic [tcprw_pkg::DATA_W-1:0]  effective_window_o
);
  import tcprw_pkg::*;

  // window state
  logic [SEG_W-1:0]  seg_q;
  logic [DATA_W-1:0] cwnd_q, cwnd_d;
  logic [DATA_W-1:0] thr_q, thr_d;
  logic [PH_W-1:0]   phase_q, phase_d;
  logic [DATA_W-1:0] aac_q, aac_d;
  logic [DUP_W-1:0]  dup_q, dup_d;
  logic [DATA_W-1:0] last_q, last_d;
  logic              grew_q, grew_d;
  logic              retx_q, retx_d;

  // captured transaction
  logic [REQ_W-1:0]  req_q;
  logic [DATA_W-1:0] ack_q;
  logic [DUP_W-1:0]  rep_q;
  logic [DATA_W-1:0] flow_q;

  // result registers
  logic              res_ack_q, res_retx_q;
  logic [DATA_W-1:0] res_win_q, res_wseg_q, res_thr_q, res_eff_q;
  logic [PH_W-1:0]   res_phase_q;

  logic              div_done;
  logic [DATA_W-1:0] quot;

  logic [DATA_W-1:0] seg_ext, seg_x2, seg_x3, seg_x16, half;
  logic [DATA_W-1:0] thr_cut, cwnd_rec, cwnd_inc;
  logic              ack_gt, ack_eq;
  logic [PH_W-1:0]   phase_g;
  logic [DATA_W-1:0] aac_g, aac_i;
  logic [DUP_W-1:0]  dup_inc;

  tcprw_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (cwnd_q),
    .divisor_i  (seg_q),
    .done_o     (div_done),
    .quotient_o (quot)
  );

  assign seg_ext  = DATA_W'(seg_q);
  assign seg_x2   = DATA_W'({seg_q, 1'b0});
  assign seg_x3   = seg_x2 + seg_ext;
  assign seg_x16  = DATA_W'({seg_q, 4'b0000});
  assign half     = {1'b0, cwnd_q[DATA_W-1:1]};
  assign thr_cut  = (half > seg_x2) ? half : seg_x2;
  assign cwnd_rec = sat_add(thr_cut, seg_x3);
  assign cwnd_inc = sat_add(cwnd_q, seg_ext);

  assign ack_gt  = ack_q > last_q;
  assign ack_eq  = ack_q == last_q;
  assign phase_g = (ack_gt && phase_q == PH_RECOV) ? PH_AVOID : phase_q;
  assign aac_g   = (ack_gt && phase_q == PH_RECOV) ? '0 : aac_q;
  assign aac_i   = (aac_g == '1) ? aac_g : aac_g + 1'b1;
  assign dup_inc = (dup_q == '1) ? dup_q : dup_q + 1'b1;

  // avoidance growth compares against cwnd / segment size first
  assign sts_o.need_pre_div = (req_q == REQ_ACK) && !ack_eq && (phase_g == PH_AVOID);
  assign sts_o.div_done     = div_done;

  always_comb begin
    cwnd_d  = cwnd_q;
    thr_d   = thr_q;
    phase_d = phase_q;
    aac_d   = aac_q;
    dup_d   = dup_q;
    last_d  = last_q;
    grew_d  = 1'b0;
    retx_d  = 1'b0;
    case (req_q)
      REQ_ACK: begin
        if (ack_eq) begin
          dup_d = dup_inc;
          if (dup_inc == DUP_TRIGGER && phase_q != PH_RECOV) begin
            thr_d   = thr_cut;
            cwnd_d  = cwnd_rec;
            phase_d = PH_RECOV;
            aac_d   = '0;
            dup_d   = '0;
            grew_d  = 1'b1;
            retx_d  = 1'b1;
          end
        end else begin
          if (ack_gt) begin
            dup_d  = '0;
            last_d = ack_q;
          end
          phase_d = phase_g;
          aac_d   = aac_g;
          case (phase_g)
            PH_SLOW: begin
              cwnd_d = cwnd_inc;
              grew_d = 1'b1;
              if (cwnd_inc >= thr_q) begin
                phase_d = PH_AVOID;
                aac_d   = '0;
              end
            end
            PH_AVOID: begin
              if (aac_i >= quot) begin
                cwnd_d = cwnd_inc;
                aac_d  = '0;
                grew_d = 1'b1;
              end else begin
                aac_d = aac_i;
              end
            end
            default: ;
          endcase
        end
      end
      REQ_DUP: begin
        dup_d = rep_q;
        if (rep_q >= DUP_TRIGGER && phase_q != PH_RECOV) begin
          thr_d   = thr_cut;
          cwnd_d  = cwnd_rec;
          phase_d = PH_RECOV;
          aac_d   = '0;
          dup_d   = '0;
          retx_d  = 1'b1;
        end
      end
      REQ_TIMEOUT: begin
        thr_d   = thr_cut;
        cwnd_d  = seg_ext;
        dup_d   = '0;
        aac_d   = '0;
        phase_d = PH_SLOW;
      end
      REQ_PARTIAL: begin
        if (phase_q == PH_RECOV) begin
          cwnd_d = cwnd_inc;
        end
      end
      REQ_REINIT: begin
        cwnd_d  = seg_ext;
        thr_d   = seg_x16;
        phase_d = PH_SLOW;
        aac_d   = '0;
        dup_d   = '0;
        last_d  = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seg_q   <= SEG_RESET;
      cwnd_q  <= DATA_W'(SEG_RESET);
      thr_q   <= DATA_W'({SEG_RESET, 4'b0000});
      phase_q <= PH_SLOW;
      aac_q   <= '0;
      dup_q   <= '0;
      last_q  <= '0;
      grew_q  <= 1'b0;
      retx_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        seg_q <= cfg_wdata_i;
      end
      if (cmd_i.apply) begin
        cwnd_q  <= cwnd_d;
        thr_q   <= thr_d;
        phase_q <= phase_d;
        aac_q   <= aac_d;
        dup_q   <= dup_d;
        last_q  <= last_d;
        grew_q  <= grew_d;
        retx_q  <= retx_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      req_q  <= req_type_i;
      ack_q  <= ack_number_i;
      rep_q  <= reported_dup_count_i;
      flow_q <= flow_window_i;
    end
    if (cmd_i.load_out) begin
      res_ack_q   <= grew_q;
      res_retx_q  <= retx_q;
      res_win_q   <= cwnd_q;
      res_wseg_q  <= quot;
      res_thr_q   <= thr_q;
      res_phase_q <= phase_q;
      res_eff_q   <= (cwnd_q < flow_q) ? cwnd_q : flow_q;
    end
  end

  assign ack_result_o       = res_ack_q;
  assign retransmit_now_o   = res_retx_q;
  assign window_bytes_o     = res_win_q;
  assign window_segments_o  = res_wseg_q;
  assign threshold_bytes_o  = res_thr_q;
  assign phase_code_o       = res_phase_q;
  assign effective_window_o = res_eff_q;

endmodule

### rtl/tcprw_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcprw_ctrl
// sequencer: capture, optional divide, apply, divide for result, hand off
// ----------------------------------------------------------------------------
module tcprw_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output tcprw_pkg::tcprw_cmd_t  cmd_o,
  input  tcprw_pkg::tcprw_sts_t  sts_i
);
  import tcprw_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_WAIT_PRE,
    ST_APPLY,
    ST_START_OUT,
    ST_WAIT_OUT,
    ST_LOAD
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   slot_free;

  assign slot_free = !out_valid_q || out_ready_i;

  always_comb begin
    cmd_o           = '0;
    cmd_o.capture   = (state_q == ST_IDLE) && in_valid_i;
    cmd_o.div_start = (state_q == ST_START_OUT) ||
                      ((state_q == ST_CHECK) && sts_i.need_pre_div);
    cmd_o.apply     = (state_q == ST_APPLY);
    cmd_o.load_out  = (state_q == ST_LOAD) && slot_free;
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      // a load refills the slot in the same cycle the old result leaves
      if (cmd_o.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            state_q <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          state_q <= sts_i.need_pre_div ? ST_WAIT_PRE : ST_APPLY;
        end
        ST_WAIT_PRE: begin
          if (sts_i.div_done) begin
            state_q <= ST_APPLY;
          end
        end
        ST_APPLY: begin
          state_q <= ST_START_OUT;
        end
        ST_START_OUT: begin
          state_q <= ST_WAIT_OUT;
        end
        ST_WAIT_OUT: begin
          if (sts_i.div_done) begin
            state_q <= ST_LOAD;
          end
        end
        ST_LOAD: begin
          if (slot_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  a_done_in_wait : assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts_i.div_done |-> (state_q == ST_WAIT_PRE || state_q == ST_WAIT_OUT))
    else $error("divider finished outside a wait state");

  a_apply_then_div : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.apply |=> cmd_o.div_start)
    else $error("result divide not started after update");

  a_valid_from_load : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_LOAD))
    else $error("result raised without a load");

endmodule

### rtl/tcp_reno_window_controller_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcp_reno_window_controller_unit
// reno-style congestion window controller, one result per event
// ----------------------------------------------------------------------------
// usage
//   input channel in_valid_i/in_ready_o carries one event transaction (request
//   type, ack number, reported duplicate count, flow window); output channel
//   out_valid_o/out_ready_i carries one result transaction per event
//   in_ready_o is high only while the sequencer is idle: one event at a time
//   in_ready_o returns as the result loads, so with a ready receiver the next
//   event is taken only after the last one's result has loaded; the shared
//   serial divider (one quotient bit per cycle) paces each event, running
//   once for cwnd / segment size before the avoidance compare, for acks that
//   land in congestion avoidance, and once for the window_segments result
//   result registers sit between the sides, so a new event is taken while a
//   finished result still waits; a stalled receiver only holds the next
//   result at its load step
//   reset sets segment size 1400, window 1400, threshold 22400, slow start,
//   all counters and the last ack to zero; the user, not the block, ensures
//   that segment size is written through cfg_we_i/cfg_wdata_i only while no
//   event is in flight
// ----------------------------------------------------------------------------
module tcp_reno_window_controller_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration
  input  logic                          cfg_we_i,
  input  logic [tcprw_pkg::SEG_W-1:0]   cfg_wdata_i,
  // event channel
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [tcprw_pkg::REQ_W-1:0]   req_type_i,
  input  logic [tcprw_pkg::DATA_W-1:0]  ack_number_i,
  input  logic [tcprw_pkg::DUP_W-1:0]   reported_dup_count_i,
  input  logic [tcprw_pkg::DATA_W-1:0]  flow_window_i,
  // result channel
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          ack_result_o,
  output logic                          retransmit_now_o,
  output logic [tcprw_pkg::DATA_W-1:0]  window_bytes_o,
  output logic [tcprw_pkg::DATA_W-1:0]  window_segments_o,
  output logic [tcprw_pkg::DATA_W-1:0]  threshold_bytes_o,
  output logic [tcprw_pkg::PH_W-1:0]    phase_code_o,
  output logic [tcprw_pkg::DATA_W-1:0]  effective_window_o
);
  import tcprw_pkg::*;

  // command and status between sequencer and datapath
  tcprw_cmd_t cmd;
  tcprw_sts_t sts;

  // sequencer: owns both handshakes and the step order
  tcprw_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  // datapath: window state, update rules, divider, result registers
  tcprw_datapath u_dp (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cmd_i                (cmd),
    .sts_o                (sts),
    .cfg_we_i             (cfg_we_i),
    .cfg_wdata_i          (cfg_wdata_i),
    .req_type_i           (req_type_i),
    .ack_number_i         (ack_number_i),
    .reported_dup_count_i (reported_dup_count_i),
    .flow_window_i        (flow_window_i),
    .ack_result_o         (ack_result_o),
    .retransmit_now_o     (retransmit_now_o),
    .window_bytes_o       (window_bytes_o),
    .window_segments_o    (window_segments_o),
    .threshold_bytes_o    (threshold_bytes_o),
    .phase_code_o         (phase_code_o),
    .effective_window_o   (effective_window_o)
  );

endmodule

### test/reno_window_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// reno_window_checker
// watches both channels and the segment size port of the window controller,
// predicts one report per event transaction and compares it field by field
// ----------------------------------------------------------------------------
module reno_window_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [tcprw_pkg::SEG_W-1:0]   cfg_wdata_i,
  input  logic                          in_valid_i,
  input  logic                          in_ready_i,
  input  logic [tcprw_pkg::REQ_W-1:0]   req_type_i,
  input  logic [tcprw_pkg::DATA_W-1:0]  ack_number_i,
  input  logic [tcprw_pkg::DUP_W-1:0]   reported_dup_count_i,
  input  logic [tcprw_pkg::DATA_W-1:0]  flow_window_i,
  input  logic                          out_valid_i,
  input  logic                          out_ready_i,
  input  logic                          ack_result_i,
  input  logic                          retransmit_now_i,
  input  logic [tcprw_pkg::DATA_W-1:0]  window_bytes_i,
  input  logic [tcprw_pkg::DATA_W-1:0]  window_segments_i,
  input  logic [tcprw_pkg::DATA_W-1:0]  threshold_bytes_i,
  input  logic [tcprw_pkg::PH_W-1:0]    phase_code_i,
  input  logic [tcprw_pkg::DATA_W-1:0]  effective_window_i,
  output int unsigned                   fail_count_o,
  output int unsigned                   pending_o
);

  import tcprw_pkg::*;

  typedef struct packed {
    logic              grew;
    logic              retx;
    logic [DATA_W-1:0] wnd_bytes;
    logic [DATA_W-1:0] wnd_segs;
    logic [DATA_W-1:0] thr_bytes;
    logic [PH_W-1:0]   phase;
    logic [DATA_W-1:0] eff_wnd;
  } window_report_t;

  logic [SEG_W-1:0]  mss;
  logic [DATA_W-1:0] cwnd;
  logic [DATA_W-1:0] ssthresh;
  logic [DATA_W-1:0] acks_in_avoid;
  logic [DATA_W-1:0] last_ack;
  logic [PH_W-1:0]   phase;
  logic [DUP_W-1:0]  dup_acks;

  window_report_t expected_reports[$];
  int unsigned    fail_count = 0;
  int unsigned    pending = 0;

  assign fail_count_o = fail_count;
  assign pending_o    = pending;

  function automatic logic [DATA_W-1:0] add_clamped(input logic [DATA_W-1:0] a,
                                                    input logic [DATA_W-1:0] b);
    logic [DATA_W-1:0] s;
    s = a + b;
    return (s < a) ? '1 : s;
  endfunction

  // a zero segment size yields a zero quotient
  function automatic logic [DATA_W-1:0] segs_of(input logic [DATA_W-1:0] bytes);
    logic [DATA_W-1:0] mss_w;
    mss_w = DATA_W'(mss);
    return (mss_w == '0) ? '0 : bytes / mss_w;
  endfunction

  task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                 input logic [DATA_W-1:0] want);
    $display("%0t: %s mismatch, got 0x%0h expected 0x%0h", $time, what, got, want);
    fail_count++;
  endtask

  task automatic restart_window();
    logic [DATA_W-1:0] mss_w;
    mss_w         = DATA_W'(mss);
    cwnd          = mss_w;
    ssthresh      = mss_w * 16;
    phase         = PH_SLOW;
    acks_in_avoid = '0;
    dup_acks      = '0;
    last_ack      = '0;
  endtask

  task automatic cut_ssthresh();
    logic [DATA_W-1:0] half;
    logic [DATA_W-1:0] floor2;
    half     = cwnd >> 1;
    floor2   = {{(DATA_W-SEG_W){1'b0}}, mss} * 2;
    ssthresh = (half > floor2) ? half : floor2;
  endtask

  task automatic fast_recovery(output bit entered);
    logic [DATA_W-1:0] mss_w;
    mss_w   = DATA_W'(mss);
    entered = 1'b0;
    if (phase != PH_RECOV) begin
      cut_ssthresh();
      cwnd          = add_clamped(ssthresh, mss_w * 3);
      phase         = PH_RECOV;
      acks_in_avoid = '0;
      dup_acks      = '0;
      entered       = 1'b1;
    end
  endtask

  // window growth for a new or an old ack
  task automatic grow_on_ack(inout logic grew);
    logic [DATA_W-1:0] mss_w;
    mss_w = DATA_W'(mss);
    if (phase == PH_SLOW) begin
      cwnd = add_clamped(cwnd, mss_w);
      if (cwnd >= ssthresh) begin
        phase         = PH_AVOID;
        acks_in_avoid = '0;
      end
      grew = 1'b1;
    end else if (phase == PH_AVOID) begin
      if (acks_in_avoid != '1) acks_in_avoid++;
      if (acks_in_avoid >= segs_of(cwnd)) begin
        cwnd          = add_clamped(cwnd, mss_w);
        acks_in_avoid = '0;
        grew          = 1'b1;
      end
    end
  endtask

  task automatic advance_window(input logic [REQ_W-1:0] kind,
                                input logic [DATA_W-1:0] ack,
                                input logic [DUP_W-1:0] reported,
                                input logic [DATA_W-1:0] flow,
                                output window_report_t rep);
    bit                entered;
    logic              grew;
    logic              retx;
    logic [DATA_W-1:0] mss_w;
    mss_w = DATA_W'(mss);
    grew  = 1'b0;
    retx  = 1'b0;
    case (kind)
      REQ_ACK: begin
        if (ack > last_ack) begin
          dup_acks = '0;
          last_ack = ack;
          if (phase == PH_RECOV) begin
            phase         = PH_AVOID;
            acks_in_avoid = '0;
          end
          grow_on_ack(grew);
        end else if (ack == last_ack) begin
          if (dup_acks != '1) dup_acks++;
          if (dup_acks == DUP_TRIGGER && phase != PH_RECOV) begin
            fast_recovery(entered);
            grew = 1'b1;
            retx = 1'b1;
          end
        end else begin
          // old ack keeps last_ack and dup_acks
          grow_on_ack(grew);
        end
      end
      REQ_DUP: begin
        dup_acks = reported;
        if (reported >= DUP_TRIGGER) begin
          fast_recovery(entered);
          retx = entered;
        end
      end
      REQ_TIMEOUT: begin
        cut_ssthresh();
        cwnd          = mss_w;
        dup_acks      = '0;
        acks_in_avoid = '0;
        phase         = PH_SLOW;
      end
      REQ_PARTIAL: begin
        if (phase == PH_RECOV) cwnd = add_clamped(cwnd, mss_w);
      end
      REQ_REINIT: begin
        restart_window();
      end
      default: begin
      end
    endcase
    rep.grew      = grew;
    rep.retx      = retx;
    rep.wnd_bytes = cwnd;
    rep.wnd_segs  = segs_of(cwnd);
    rep.thr_bytes = ssthresh;
    rep.phase     = phase;
    rep.eff_wnd   = (cwnd < flow) ? cwnd : flow;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    window_report_t want;
    window_report_t got;
    if (!rst_ni) begin
      mss = SEG_RESET;
      restart_window();
      expected_reports.delete();
      pending = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (expected_reports.size() == 0) begin
          report_mismatch("unexpected result, window_bytes", window_bytes_i, '0);
        end else begin
          want = expected_reports.pop_front();
          pending--;
          if (ack_result_i !== want.grew)
            report_mismatch("ack_result", DATA_W'(ack_result_i), DATA_W'(want.grew));
          if (retransmit_now_i !== want.retx)
            report_mismatch("retransmit_now", DATA_W'(retransmit_now_i),
                            DATA_W'(want.retx));
          if (window_bytes_i !== want.wnd_bytes)
            report_mismatch("window_bytes", window_bytes_i, want.wnd_bytes);
          if (window_segments_i !== want.wnd_segs)
            report_mismatch("window_segments", window_segments_i, want.wnd_segs);
          if (threshold_bytes_i !== want.thr_bytes)
            report_mismatch("threshold_bytes", threshold_bytes_i, want.thr_bytes);
          if (phase_code_i !== want.phase)
            report_mismatch("phase_code", DATA_W'(phase_code_i), DATA_W'(want.phase));
          if (effective_window_i !== want.eff_wnd)
            report_mismatch("effective_window", effective_window_i, want.eff_wnd);
        end
      end
      if (cfg_we_i) mss = cfg_wdata_i;
      if (in_valid_i && in_ready_i) begin
        advance_window(req_type_i, ack_number_i, reported_dup_count_i, flow_window_i, got);
        expected_reports.push_back(got);
        pending++;
      end
    end
  end

endmodule

### test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// drives event transactions into the reno window controller and gives the
// verdict; a directed sequence walks slow start, duplicate acks, fast
// recovery, partial and old acks, timeouts and reinit, then random ack
// streams run under several segment sizes with random stalls on both sides
// ----------------------------------------------------------------------------
module tb_top;

  import tcprw_pkg::*;

  localparam int unsigned CYCLE_LIMIT    = 1_000_000;
  localparam int unsigned DRAIN_CYCLES   = 100;   // above the worst-case latency with a ready receiver
  localparam int unsigned RX_HOLD_AT     = 200;   // results seen before the long hold-off
  localparam int unsigned RX_HOLD_CYCLES = 400;
  localparam int unsigned RX_CALM_FROM   = 300;   // receiver never stalls in this window
  localparam int unsigned RX_CALM_TO     = 450;
  localparam int unsigned NUM_PHASES     = 6;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [SEG_W-1:0]     cfg_wdata_i;
  logic                 in_valid_i;
  logic                 in_ready_o;
  logic [REQ_W-1:0]     req_type_i;
  logic [DATA_W-1:0]    ack_number_i;
  logic [DUP_W-1:0]     reported_dup_count_i;
  logic [DATA_W-1:0]    flow_window_i;
  logic                 out_valid_o;
  logic                 out_ready_i;
  logic                 ack_result_o;
  logic                 retransmit_now_o;
  logic [DATA_W-1:0]    window_bytes_o;
  logic [DATA_W-1:0]    window_segments_o;
  logic [DATA_W-1:0]    threshold_bytes_o;
  logic [PH_W-1:0]      phase_code_o;
  logic [DATA_W-1:0]    effective_window_o;

  int unsigned          fail_count;
  int unsigned          pending;
  int unsigned          cycle_count = 0;

  // sender-side view of the connection: highest ack offered as new
  logic [DATA_W-1:0]    ack_cursor;
  bit                   sender_calm;

  tcp_reno_window_controller_unit dut (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cfg_we_i             (cfg_we_i),
    .cfg_wdata_i          (cfg_wdata_i),
    .in_valid_i           (in_valid_i),
    .in_ready_o           (in_ready_o),
    .req_type_i           (req_type_i),
    .ack_number_i         (ack_number_i),
    .reported_dup_count_i (reported_dup_count_i),
    .flow_window_i        (flow_window_i),
    .out_valid_o          (out_valid_o),
    .out_ready_i          (out_ready_i),
    .ack_result_o         (ack_result_o),
    .retransmit_now_o     (retransmit_now_o),
    .window_bytes_o       (window_bytes_o),
    .window_segments_o    (window_segments_o),
    .threshold_bytes_o    (threshold_bytes_o),
    .phase_code_o         (phase_code_o),
    .effective_window_o   (effective_window_o)
  );

  // checker sits beside the block and sees exactly what crosses its ports
  reno_window_checker u_checker (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cfg_we_i             (cfg_we_i),
    .cfg_wdata_i          (cfg_wdata_i),
    .in_valid_i           (in_valid_i),
    .in_ready_i           (in_ready_o),
    .req_type_i           (req_type_i),
    .ack_number_i         (ack_number_i),
    .reported_dup_count_i (reported_dup_count_i),
    .flow_window_i        (flow_window_i),
    .out_valid_i          (out_valid_o),
    .out_ready_i          (out_ready_i),
    .ack_result_i         (ack_result_o),
    .retransmit_now_i     (retransmit_now_o),
    .window_bytes_i       (window_bytes_o),
    .window_segments_i    (window_segments_o),
    .threshold_bytes_i    (threshold_bytes_o),
    .phase_code_i         (phase_code_o),
    .effective_window_i   (effective_window_o),
    .fail_count_o         (fail_count),
    .pending_o            (pending)
  );

  // 4 ns clock
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // run limit, sized far above the slowest legal run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count, pending);
      $display("Simulation FAILED");
      $finish;
    end
  end

  // result side: random stalls, one long hold-off while the sender keeps
  // offering so the result registers fill and in_ready_o drops, and a calm
  // window where every result is taken at once
  initial begin : receiver
    int unsigned rx_seen;
    int unsigned hold_left;
    bit          held;
    rx_seen     = 0;
    hold_left   = 0;
    held        = 1'b0;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) rx_seen++;
      if (hold_left != 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (!held && rx_seen >= RX_HOLD_AT) begin
        held      = 1'b1;
        hold_left = RX_HOLD_CYCLES;
        out_ready_i <= 1'b0;
      end else if (rx_seen >= RX_CALM_FROM && rx_seen < RX_CALM_TO) begin
        out_ready_i <= 1'b1;
      end else begin
        out_ready_i <= ($urandom_range(99) >= 35);
      end
    end
  end

  // small windows and full-range random values in equal share, plus both extremes
  function automatic logic [DATA_W-1:0] pick_flow();
    int unsigned r;
    r = $urandom_range(9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    if (r < 6) return DATA_W'($urandom_range(200000));
    return DATA_W'($urandom);
  endfunction

  // one event transaction; valid holds with a stable payload until accepted
  task automatic send_event(input logic [REQ_W-1:0] kind, input logic [DATA_W-1:0] ack,
                            input logic [DUP_W-1:0] reported,
                            input logic [DATA_W-1:0] flow);
    int unsigned r;
    int unsigned gap;
    gap = 0;
    if (!sender_calm) begin
      r = $urandom_range(99);
      // short gaps mostly, long ones so idle time also lands on an empty block
      if (r < 5) gap = $urandom_range(90, 20);
      else if (r < 35) gap = $urandom_range(4, 1);
    end
    repeat (gap) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i           <= 1'b1;
    req_type_i           <= kind;
    ack_number_i         <= ack;
    reported_dup_count_i <= reported;
    flow_window_i        <= flow;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // stop offering and wait until every predicted result has been taken
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0 || !in_ready_o) @(posedge clk_i);
  endtask

  task automatic write_segment_size(input logic [SEG_W-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // walk through every request type and the corner behaviors at mss 1400
  task automatic directed_events();
    send_event(REQ_ACK, 32'd0, 8'd0, '1);          // equal to last ack: first duplicate
    send_event(REQ_ACK, 32'd0, 8'd0, '0);          // second duplicate
    send_event(REQ_ACK, 32'd0, 8'd0, 32'd3000);    // third duplicate enters fast recovery
    send_event(REQ_PARTIAL, '1, '1, 32'd50000);    // inflate during recovery
    send_event(REQ_ACK, 32'd0, 8'd0, '1);          // duplicate inside recovery, no re-entry
    send_event(REQ_ACK, 32'd1000, 8'd0, '1);       // new ack leaves recovery for avoidance
    send_event(REQ_ACK, 32'd500, 8'd0, '1);        // old ack grows as in avoidance
    send_event(REQ_DUP, 32'd0, 8'd2, '1);          // count below the trigger
    send_event(REQ_DUP, '1, 8'd255, 32'd1);        // count at the top enters recovery
    send_event(REQ_ACK, 32'd400, 8'd0, '1);        // old ack in recovery does not grow
    send_event(REQ_DUP, 32'd0, 8'd255, '1);        // already in recovery, count kept
    send_event(REQ_ACK, 32'd1000, 8'd0, '1);       // duplicate count saturates at 255
    send_event(REQ_PARTIAL, 32'd0, 8'd0, '1);
    send_event(REQ_TIMEOUT, '1, '1, '1);           // back to slow start
    send_event(REQ_PARTIAL, 32'd0, 8'd0, '1);      // outside recovery: no change
    send_event(REQ_DUP, 32'd0, 8'd0, '0);
    send_event(REQ_ACK, '1, 8'd0, 32'd2000);       // largest ack number
    send_event(REQ_ACK, 32'd0, '1, '1);            // old ack in slow start
    send_event(3'd5, '1, '1, '1);                  // unknown request types report state
    send_event(3'd6, 32'h5555_5555, 8'haa, 32'd100);
    send_event(3'd7, 32'haaaa_aaaa, 8'h55, '0);
    send_event(REQ_REINIT, '1, '1, '1);
    send_event(REQ_ACK, 32'd1, 8'd0, 32'd2800);
    ack_cursor = 32'd1;
  endtask

  // random connection traffic: mostly rising acks with duplicate bursts and
  // recovery traffic, some timeouts, reinit, old acks and unknown types
  task automatic random_events(input int unsigned count);
    int unsigned       sent;
    int unsigned       r;
    int unsigned       burst;
    logic [DATA_W-1:0] next_ack;
    logic [DATA_W-1:0] step;
    logic [DUP_W-1:0]  reported;
    sent = 0;
    while (sent < count) begin
      r = $urandom_range(99);
      if (r < 50) begin
        if ($urandom_range(49) == 0 && ack_cursor < 32'h8000_0000) step = DATA_W'($urandom);
        else step = DATA_W'($urandom_range(3000, 1));
        next_ack = ack_cursor + step;
        // on a wrap the cursor stays put and the event goes out as an old ack
        if (next_ack > ack_cursor) ack_cursor = next_ack;
        send_event(REQ_ACK, next_ack, DUP_W'($urandom), pick_flow());
        sent++;
      end else if (r < 64) begin
        burst = $urandom_range(4, 1);
        repeat (burst) begin
          send_event(REQ_ACK, ack_cursor, DUP_W'($urandom), pick_flow());
          sent++;
        end
      end else if (r < 73) begin
        send_event(REQ_PARTIAL, DATA_W'($urandom), DUP_W'($urandom), pick_flow());
        sent++;
      end else if (r < 78) begin
        if (ack_cursor != '0) begin
          send_event(REQ_ACK, DATA_W'($urandom_range(ack_cursor - 1)), DUP_W'($urandom),
                     pick_flow());
          sent++;
        end
      end else if (r < 84) begin
        if ($urandom_range(3) == 0) reported = DUP_W'($urandom);
        else reported = DUP_W'($urandom_range(5));
        send_event(REQ_DUP, DATA_W'($urandom), reported, pick_flow());
        sent++;
      end else if (r < 89) begin
        send_event(REQ_TIMEOUT, DATA_W'($urandom), DUP_W'($urandom), pick_flow());
        sent++;
      end else if (r < 92) begin
        send_event(REQ_REINIT, DATA_W'($urandom), DUP_W'($urandom), pick_flow());
        ack_cursor = '0;
        sent++;
      end else begin
        // noise, not counted
        send_event(REQ_W'($urandom_range(7, 5)), DATA_W'($urandom), DUP_W'($urandom),
                   pick_flow());
      end
    end
  endtask

  initial begin : stimulus
    int unsigned      items;
    logic [SEG_W-1:0] seg;
    rst_ni               = 1'b0;
    cfg_we_i             = 1'b0;
    cfg_wdata_i          = '0;
    in_valid_i           = 1'b0;
    req_type_i           = REQ_ACK;
    ack_number_i         = '0;
    reported_dup_count_i = '0;
    flow_window_i        = '0;
    ack_cursor           = '0;
    sender_calm          = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    directed_events();

    // segment size sweep: smallest, largest, zero, then 536, a random size and 1460
    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: begin seg = 16'd1;     items = 120; end
        1: begin seg = 16'd65535; items = 120; end
        2: begin seg = 16'd0;     items = 40;  end
        3: begin seg = 16'd536;   items = 140; end
        4: begin seg = SEG_W'($urandom_range(65534, 2)); items = 140; end
        default: begin seg = 16'd1460; items = 140; end
      endcase
      // sender pauses until every result has come, then the register is written
      drain();
      write_segment_size(seg);
      sender_calm = (p == 3);
      random_events(items);
    end

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
